/* design/ple_pkg.sv */
package ple_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 8;
	localparam int DATA_W   = 32;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic load;
		logic exec;
		logic publish;
	} ple_cmd_t;

endpackage

/* design/ple_req_if.sv */
interface ple_req_if;
	import ple_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               opcode;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value_in;

	modport source (output valid, output opcode, output position, output value_in, input ready);
	modport sink   (input valid, input opcode, input position, input value_in, output ready);
endinterface

/* design/ple_rsp_if.sv */
interface ple_rsp_if;
	import ple_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] value_out;
	logic [CNT_W-1:0]         entry_count;
	logic signed [DATA_W-1:0] middle_value;
	logic                     middle_valid;

	modport source (
		output valid, output status, output value_out, output entry_count,
		output middle_value, output middle_valid, input ready
	);
	modport sink (
		input valid, input status, input value_out, input entry_count,
		input middle_value, input middle_valid, output ready
	);
endinterface

/* design/positional_list_engine_core.sv */
// An accepted request beat is registered at load, executed, and its result is published in
// middle capture; the controller runs load, execute and middle capture in turn, so a new
// request is taken only once the previous result is staged.
// A stalled result holds the next operation in middle capture until the beat is taken.
// Reset (arst_n low) empties the list and clears the controller; stored entries keep
// whatever they held and are only read after being written.
module positional_list_engine_core (
	input  logic       clk,
	input  logic       arst_n,
	ple_req_if.sink    req,
	ple_rsp_if.source  rsp
);
	import ple_pkg::*;

	ple_cmd_t cmd;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	ple_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.opcode       (req.opcode),
		.position     (req.position),
		.value_in     (req.value_in),
		.status       (rsp.status),
		.value_out    (rsp.value_out),
		.entry_count  (rsp.entry_count),
		.middle_value (rsp.middle_value),
		.middle_valid (rsp.middle_valid)
	);

endmodule

/* design/ple_ctrl.sv */
module ple_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output ple_pkg::ple_cmd_t cmd
);
	import ple_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_MID  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       publish;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign publish   = (state_q == S_MID) && (!out_valid_q || rsp_ready);
	assign rsp_valid = out_valid_q;

	assign cmd.load    = accept;
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.publish = publish;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_MID;
			end
			S_MID: begin
				if (publish) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC)
		else $error("accepted beat did not start execution");

	a_exec_to_mid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |=> state_q == S_MID)
		else $error("execution did not advance to middle capture");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MID && out_valid_q && !rsp_ready) |=> state_q == S_MID)
		else $error("result overwritten while previous beat was pending");

	a_publish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		publish |=> out_valid_q)
		else $error("published result not presented");

endmodule

/* design/ple_dpath.sv */
module ple_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ple_pkg::ple_cmd_t                 cmd,
	input  logic [1:0]                        opcode,
	input  logic [ple_pkg::POS_W-1:0]         position,
	input  logic signed [ple_pkg::DATA_W-1:0] value_in,
	output logic [1:0]                        status,
	output logic signed [ple_pkg::DATA_W-1:0] value_out,
	output logic [ple_pkg::CNT_W-1:0]         entry_count,
	output logic signed [ple_pkg::DATA_W-1:0] middle_value,
	output logic                              middle_valid
);
	import ple_pkg::*;

	logic signed [DATA_W-1:0] entries_q [CAPACITY];
	logic [CNT_W-1:0]         count_q;
	logic [1:0]               op_q;
	logic [POS_W-1:0]         pos_q;
	logic signed [DATA_W-1:0] value_q;
	logic [1:0]               status_q;
	logic signed [DATA_W-1:0] rd_q;

	logic                     full;
	logic                     empty;
	logic                     pos_zero;
	logic                     past_end;
	logic [IDX_W-1:0]         pos_idx;
	logic [IDX_W-1:0]         ins_at;
	logic [IDX_W-1:0]         mid_idx;
	logic                     do_ins;
	logic                     do_del;
	logic [1:0]               next_status;
	logic signed [DATA_W-1:0] next_rd;

	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign pos_zero = (pos_q == '0);
	assign past_end = (CMP_W'(pos_q) > CMP_W'(count_q));
	assign pos_idx  = IDX_W'(pos_q - POS_W'(1));
	assign ins_at   = past_end ? IDX_W'(count_q) : pos_idx;
	assign mid_idx  = IDX_W'(count_q >> 1);

	always_comb begin
		next_status = ST_OK;
		next_rd     = '0;
		do_ins      = 1'b0;
		do_del      = 1'b0;
		unique case (op_q)
			OP_INSERT: begin
				if (full) begin
					next_status = ST_FULL;
				end else if (pos_zero) begin
					next_status = ST_NOT_FOUND;
				end else begin
					do_ins = 1'b1;
				end
			end
			OP_DELETE: begin
				if (empty) begin
					next_status = ST_EMPTY;
				end else if (pos_zero || past_end) begin
					next_status = ST_NOT_FOUND;
				end else begin
					do_del = 1'b1;
				end
			end
			OP_READ: begin
				if (empty) begin
					next_status = ST_EMPTY;
				end else if (pos_zero || past_end) begin
					next_status = ST_NOT_FOUND;
				end else begin
					next_rd = entries_q[pos_idx];
				end
			end
			default: begin
				next_status = ST_OK;
			end
		endcase
	end

	// Entries at and above the target index move together: up by one on an insert, down by one on a delete.
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (cmd.exec && do_ins) begin
				if (IDX_W'(i) == ins_at) begin
					entries_q[IDX_W'(i)] <= value_q;
				end else if (IDX_W'(i) > ins_at) begin
					entries_q[IDX_W'(i)] <= entries_q[IDX_W'((i == 0) ? 0 : i - 1)];
				end
			end else if (cmd.exec && do_del && IDX_W'(i) >= pos_idx) begin
				entries_q[IDX_W'(i)] <= entries_q[IDX_W'((i == CAPACITY - 1) ? i : i + 1)];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (do_ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_del) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			pos_q   <= position;
			value_q <= value_in;
		end
		if (cmd.exec) begin
			status_q <= next_status;
			rd_q     <= next_rd;
		end
		if (cmd.publish) begin
			status       <= status_q;
			value_out    <= rd_q;
			entry_count  <= count_q;
			middle_value <= empty ? '0 : entries_q[mid_idx];
			middle_valid <= !empty;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(count_q))
		else $error("entry count changed outside execution");

	a_no_grow_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && full) |=> count_q <= $past(count_q))
		else $error("insert into a full list changed the count");

endmodule

/* tb/ple_list_check.sv */
module ple_list_check (
	input  logic clk,
	input  logic arst_n,
	ple_req_if   req,
	ple_rsp_if   rsp,
	output int   failures,
	output int   pending,
	output int   held
);
	import ple_pkg::*;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] value_out;
		logic [CNT_W-1:0]         entry_count;
		logic signed [DATA_W-1:0] middle_value;
		logic                     middle_valid;
	} list_result_t;

	logic signed [DATA_W-1:0] list_q[$];
	list_result_t             due_q[$];
	list_result_t             want;

	task automatic report(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] exp_val);
		$display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, exp_val);
		failures++;
	endtask

	function automatic list_result_t apply_list_op(input logic [1:0] op,
			input logic [POS_W-1:0] pos, input logic signed [DATA_W-1:0] val);
		list_result_t r;
		int n;
		int p;
		r = '0;
		r.status = ST_OK;
		n = list_q.size();
		p = int'(pos);
		case (op)
		OP_INSERT: begin
			if (n >= CAPACITY)
				r.status = ST_FULL;
			else if (p == 0)
				r.status = ST_NOT_FOUND;
			else
				list_q.insert((p > n) ? n : p - 1, val);
		end
		OP_DELETE: begin
			if (n == 0)
				r.status = ST_EMPTY;
			else if (p == 0 || p > n)
				r.status = ST_NOT_FOUND;
			else
				list_q.delete(p - 1);
		end
		OP_READ: begin
			if (n == 0)
				r.status = ST_EMPTY;
			else if (p == 0 || p > n)
				r.status = ST_NOT_FOUND;
			else
				r.value_out = list_q[p - 1];
		end
		default: begin
		end
		endcase
		n = list_q.size();
		r.entry_count = n[CNT_W-1:0];
		if (n > 0) begin
			r.middle_value = list_q[n / 2];
			r.middle_valid = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_q.delete();
			due_q.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_q.size() == 0) begin
					report("unexpected result beat", '0, '0);
				end else begin
					want = due_q.pop_front();
					if (rsp.status !== want.status)
						report("status", DATA_W'(rsp.status), DATA_W'(want.status));
					if (rsp.value_out !== want.value_out)
						report("value_out", rsp.value_out, want.value_out);
					if (rsp.entry_count !== want.entry_count)
						report("entry_count", DATA_W'(rsp.entry_count),
							DATA_W'(want.entry_count));
					if (rsp.middle_value !== want.middle_value)
						report("middle_value", rsp.middle_value, want.middle_value);
					if (rsp.middle_valid !== want.middle_valid)
						report("middle_valid", DATA_W'(rsp.middle_valid),
							DATA_W'(want.middle_valid));
				end
			end
			if (req.valid && req.ready)
				due_q.push_back(apply_list_op(req.opcode, req.position, req.value_in));
		end
		pending = due_q.size();
		held = list_q.size();
	end

endmodule

/* tb/tb_positional_list_engine_core.sv */
module tb_positional_list_engine_core;
	import ple_pkg::*;

	localparam logic [1:0] OP_IDLE = 2'd3;
	localparam int ITEM_GOAL = 1150;
	localparam int CYCLE_LIMIT = 300000;

	typedef enum {BURST_MIXED, BURST_FILL, BURST_DRAIN, BURST_SWEEP} burst_t;

	logic clk;
	logic arst_n;
	int   failures;
	int   pending;
	int   held;
	int   src_idle_pct;
	int   snk_stall_pct;
	int   hold_cycles;
	int   issued;
	int   cycles;

	ple_req_if req ();
	ple_rsp_if rsp ();

	positional_list_engine_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	ple_list_check list_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.failures (failures),
		.pending  (pending),
		.held     (held)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				rsp.ready <= 1'b0;
				hold_cycles--;
			end else begin
				rsp.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	task automatic push_op(input logic [1:0] op, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.position <= pos;
		req.value_in <= val;
		do
			@(posedge clk);
		while (!req.ready);
		issued++;
		@(negedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return '0;
		3: return '1;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_pos(input int span);
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return POS_W'($urandom_range(255));
		return POS_W'($urandom_range((span < 1) ? 1 : span, 1));
	endfunction

	task automatic run_burst(input burst_t kind, input int n);
		logic [1:0]       op;
		logic [POS_W-1:0] pos;
		int               r;
		for (int i = 0; i < n; i++) begin
			case (kind)
			BURST_FILL: op = ($urandom_range(9) != 0) ? OP_INSERT : OP_READ;
			BURST_DRAIN: op = ($urandom_range(9) != 0) ? OP_DELETE : OP_READ;
			BURST_SWEEP: op = OP_READ;
			default: begin
				r = $urandom_range(99);
				op = (r < 38) ? OP_INSERT : (r < 68) ? OP_DELETE : (r < 95) ? OP_READ : OP_IDLE;
			end
			endcase
			if (kind == BURST_SWEEP)
				pos = POS_W'(i + 1);
			else
				pos = pick_pos((op == OP_INSERT) ? held + 1 : held);
			push_op(op, pos, pick_value());
		end
	endtask

	initial begin
		burst_t kind;
		int     k;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.opcode = OP_INSERT;
		req.position = '0;
		req.value_in = '0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		push_op(OP_READ, 8'd1, 32'sd5);
		push_op(OP_DELETE, 8'd1, 32'sd5);
		push_op(OP_IDLE, 8'd0, $urandom);
		push_op(OP_INSERT, 8'd0, 32'sd7);
		push_op(OP_INSERT, 8'd255, 32'h7FFF_FFFF);
		push_op(OP_INSERT, 8'd1, 32'h8000_0000);
		push_op(OP_INSERT, 8'd2, 32'hFFFF_FFFF);
		push_op(OP_INSERT, 8'd200, 32'sd0);
		push_op(OP_READ, 8'd0, 32'sd0);
		push_op(OP_READ, 8'd4, 32'sd0);
		push_op(OP_READ, 8'd5, 32'sd0);
		push_op(OP_READ, 8'd255, 32'sd0);
		push_op(OP_DELETE, 8'd0, 32'sd0);
		push_op(OP_DELETE, 8'd5, 32'sd0);
		push_op(OP_DELETE, 8'd4, 32'sd0);
		push_op(OP_DELETE, 8'd1, 32'sd0);
		push_op(OP_IDLE, 8'd255, 32'hFFFF_FFFF);
		push_op(OP_READ, 8'd1, 32'sd0);
		push_op(OP_DELETE, 8'd1, 32'sd0);
		push_op(OP_DELETE, 8'd1, 32'sd0);
		push_op(OP_READ, 8'd1, 32'sd0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin
				src_idle_pct = 0;
				snk_stall_pct = 0;
			end
			1: begin
				src_idle_pct = 83;
				snk_stall_pct = 0;
			end
			2: begin
				src_idle_pct = 0;
				snk_stall_pct = 83;
			end
			default: begin
				src_idle_pct = 18;
				snk_stall_pct = 18;
			end
			endcase
			// The receiver holds off while beats keep coming, so the core backs up.
			if (ph == 0) begin
				hold_cycles = 120;
				run_burst(BURST_FILL, 40);
			end
			while (issued < ITEM_GOAL * (ph + 1) / 4) begin
				k = $urandom_range(9);
				kind = (k < 4) ? BURST_MIXED : (k < 6) ? BURST_FILL :
					(k < 8) ? BURST_DRAIN : BURST_SWEEP;
				run_burst(kind, (kind == BURST_SWEEP) ? held + 2 :
					(kind == BURST_MIXED) ? $urandom_range(40, 10) : 40);
			end
			req.valid <= 1'b0;
			wait (pending == 0);
			@(negedge clk);
		end

		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
